/* hw/rtl/gtp_pkg.sv */
// Shared constants, status codes and the result record of the GTPv1 header parser.
package gtp_pkg;

  localparam int CNT_W = 17;
  localparam logic [CNT_W-1:0] CNT_MAX  = 17'h1FFFF;
  localparam logic [CNT_W-1:0] HDR_MIN  = 17'd8;
  localparam logic [CNT_W-1:0] HDR_CTRL = 17'd12;

  // Flag bits of the first octet
  localparam logic [2:0] FLAG_PN = 3'h1;
  localparam logic [2:0] FLAG_S  = 3'h2;
  localparam logic [2:0] FLAG_E  = 3'h4;
  localparam logic [7:0] PT_BIT  = 8'h10;
  localparam logic [2:0] GTP_VERSION = 3'd1;

  // Byte positions of the fixed header
  localparam logic [CNT_W-1:0] POS_FLAGS = 17'd0;
  localparam logic [CNT_W-1:0] POS_TYPE  = 17'd1;
  localparam logic [CNT_W-1:0] POS_LEN_H = 17'd2;
  localparam logic [CNT_W-1:0] POS_LEN_L = 17'd3;
  localparam logic [CNT_W-1:0] POS_TEID0 = 17'd4;
  localparam logic [CNT_W-1:0] POS_TEID3 = 17'd7;
  localparam logic [CNT_W-1:0] POS_SEQ_H = 17'd8;
  localparam logic [CNT_W-1:0] POS_SEQ_L = 17'd9;
  localparam logic [CNT_W-1:0] POS_NPDU  = 17'd10;
  localparam logic [CNT_W-1:0] POS_NEXT  = 17'd11;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_VERSION = 2'd2;
  localparam logic [1:0] ST_LENGTH  = 2'd3;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] header_length;
    logic [7:0]       msg_type;
    logic [15:0]      payload_length;
    logic [31:0]      tunnel_id;
    logic [15:0]      sequence_number;
    logic [7:0]       npdu_number;
    logic [7:0]       first_ext_type;
    logic             ext_flag;
    logic             seq_flag;
    logic             npdu_flag;
  } res_t;

endpackage

/* hw/rtl/gtp_ifs.sv */
// Byte input and result channel interfaces of the GTPv1 header parser.
interface gtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface gtp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [16:0] header_length;
  logic [7:0]  msg_type;
  logic [15:0] payload_length;
  logic [31:0] tunnel_id;
  logic [15:0] sequence_number;
  logic [7:0]  npdu_number;
  logic [7:0]  first_ext_type;
  logic        ext_flag;
  logic        seq_flag;
  logic        npdu_flag;

  modport source (output valid, output status, output header_length, output msg_type,
                  output payload_length, output tunnel_id, output sequence_number,
                  output npdu_number, output first_ext_type, output ext_flag,
                  output seq_flag, output npdu_flag, input ready);
  modport sink   (input valid, input status, input header_length, input msg_type,
                  input payload_length, input tunnel_id, input sequence_number,
                  input npdu_number, input first_ext_type, input ext_flag,
                  input seq_flag, input npdu_flag, output ready);
endinterface

/* hw/rtl/gtp_v1_header_parser.sv */
// GTPv1 header parser: byte-serial header decode and extension chain walk.
// Throughput: one byte beat per cycle while input is not stalled; a result beat is emitted per buffer.
// The last byte beat is captured in the input register and parsed out of it into the result
//   register, which raises the result beat valid; a held result can keep it in the input register.
// A held result stalls input only when the next buffer's last byte reaches parsing.
// Reset (rst_n low, synchronous) empties both registers and clears the parse state.
module gtp_v1_header_parser (
  input  logic      clk,
  input  logic      rst_n,
  gtp_in_if.sink    in_chan,
  gtp_out_if.source out_chan
);
  import gtp_pkg::*;

  // Input register
  logic       s1_vld_r;
  logic [7:0] s1_data_r;
  logic       s1_last_r;
  logic       s1_adv;
  logic       take;

  // Parse state
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]       flags_r, flags_nxt;
  logic             early_r, early_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [31:0]      teid_r, teid_nxt;
  logic [15:0]      seq_r, seq_nxt;
  logic [7:0]       npdu_r, npdu_nxt;
  logic [7:0]       fext_r, fext_nxt;
  logic [7:0]       pend_r, pend_nxt;
  logic [CNT_W-1:0] xstart_r, xstart_nxt;
  logic [CNT_W-1:0] xend_r, xend_nxt;
  logic             werr_r, werr_nxt;

  // Updated values for the byte in the input register
  logic [CNT_W-1:0] u_cnt;
  logic [2:0]       u_flags;
  logic             u_early;
  logic [7:0]       u_type;
  logic [15:0]      u_len;
  logic [31:0]      u_teid;
  logic [15:0]      u_seq;
  logic [7:0]       u_npdu;
  logic [7:0]       u_fext;
  logic [7:0]       u_pend;
  logic [CNT_W-1:0] u_xstart;
  logic [CNT_W-1:0] u_xend;
  logic             u_werr;

  logic [CNT_W-1:0] total_old;
  logic [CNT_W-1:0] total_new;
  logic [9:0]       ext_n;
  logic [CNT_W:0]   ext_sum;

  // Result register
  logic out_vld_r, out_vld_nxt;
  res_t res_r;
  res_t res_nxt;
  logic any_flag;

  // Advance the input register unless a last byte would overwrite a held result
  assign s1_adv = s1_vld_r && !(s1_last_r && out_vld_r && !out_chan.ready);
  assign in_chan.ready = !s1_vld_r || s1_adv;
  assign take = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_data_r <= in_chan.data_byte;
      s1_last_r <= in_chan.last_byte;
    end
  end

  // Decode one byte by its position
  assign total_old = HDR_MIN + {1'b0, len_r};
  assign ext_n     = {s1_data_r, 2'b00};
  assign ext_sum   = {1'b0, xstart_r} + {{(CNT_W-9){1'b0}}, ext_n};

  always_comb begin
    u_cnt    = (cnt_r < CNT_MAX) ? cnt_r + 17'd1 : cnt_r;
    u_flags  = flags_r;
    u_early  = early_r;
    u_type   = type_r;
    u_len    = len_r;
    u_teid   = teid_r;
    u_seq    = seq_r;
    u_npdu   = npdu_r;
    u_fext   = fext_r;
    u_pend   = pend_r;
    u_xstart = xstart_r;
    u_xend   = xend_r;
    u_werr   = werr_r;
    case (cnt_r)
      POS_FLAGS: begin
        u_flags = s1_data_r[2:0];
        u_early = (s1_data_r[7:5] != GTP_VERSION) || ((s1_data_r & PT_BIT) == 8'h00);
      end
      POS_TYPE:  u_type = s1_data_r;
      POS_LEN_H: u_len  = {s1_data_r, 8'h00};
      POS_LEN_L: u_len  = {len_r[15:8], s1_data_r};
      POS_TEID0, 17'd5, 17'd6, POS_TEID3: u_teid = {teid_r[23:0], s1_data_r};
      POS_SEQ_H: u_seq  = {s1_data_r, 8'h00};
      POS_SEQ_L: u_seq  = {seq_r[15:8], s1_data_r};
      POS_NPDU:  u_npdu = s1_data_r;
      POS_NEXT: begin
        u_fext = s1_data_r;
        if ((flags_r & FLAG_E) != 3'h0) begin
          u_pend = s1_data_r;
        end
      end
      default: begin
        // Walk the extension chain: length octet, then next-type octet
        if (!werr_r && pend_r != 8'h00) begin
          if (xend_r != '0) begin
            if (cnt_r == xend_r) begin
              u_pend   = s1_data_r;
              u_xstart = cnt_r + 17'd1;
              u_xend   = '0;
            end
          end else if (cnt_r == xstart_r) begin
            if (xstart_r >= total_old || ext_n == 10'd0 ||
                ext_sum > {1'b0, total_old}) begin
              u_werr = 1'b1;
            end else begin
              u_xend = ext_sum[CNT_W-1:0] - 17'd1;
            end
          end
        end
      end
    endcase
  end

  // Hold, advance, or return to reset after the last byte
  always_comb begin
    cnt_nxt = cnt_r;   flags_nxt = flags_r; early_nxt = early_r; type_nxt = type_r;
    len_nxt = len_r;   teid_nxt = teid_r;   seq_nxt = seq_r;     npdu_nxt = npdu_r;
    fext_nxt = fext_r; pend_nxt = pend_r;   xstart_nxt = xstart_r;
    xend_nxt = xend_r; werr_nxt = werr_r;
    if (s1_adv) begin
      if (s1_last_r) begin
        cnt_nxt = '0;    flags_nxt = '0; early_nxt = 1'b0; type_nxt = '0;
        len_nxt = '0;    teid_nxt = '0;  seq_nxt = '0;     npdu_nxt = '0;
        fext_nxt = '0;   pend_nxt = '0;  xstart_nxt = HDR_CTRL;
        xend_nxt = '0;   werr_nxt = 1'b0;
      end else begin
        cnt_nxt = u_cnt;   flags_nxt = u_flags; early_nxt = u_early; type_nxt = u_type;
        len_nxt = u_len;   teid_nxt = u_teid;   seq_nxt = u_seq;     npdu_nxt = u_npdu;
        fext_nxt = u_fext; pend_nxt = u_pend;   xstart_nxt = u_xstart;
        xend_nxt = u_xend; werr_nxt = u_werr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;    flags_r <= '0; early_r <= 1'b0; type_r <= '0;
      len_r <= '0;    teid_r <= '0;  seq_r <= '0;     npdu_r <= '0;
      fext_r <= '0;   pend_r <= '0;  xstart_r <= HDR_CTRL;
      xend_r <= '0;   werr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;   flags_r <= flags_nxt; early_r <= early_nxt; type_r <= type_nxt;
      len_r <= len_nxt;   teid_r <= teid_nxt;   seq_r <= seq_nxt;     npdu_r <= npdu_nxt;
      fext_r <= fext_nxt; pend_r <= pend_nxt;   xstart_r <= xstart_nxt;
      xend_r <= xend_nxt; werr_r <= werr_nxt;
    end
  end

  // Build the result from the updated state, checks in priority order
  assign total_new = HDR_MIN + {1'b0, u_len};
  assign any_flag  = u_flags != 3'h0;

  always_comb begin
    logic fields;
    logic opt;
    fields  = 1'b0;
    opt     = 1'b0;
    res_nxt = '0;
    if (u_cnt < HDR_MIN) begin
      res_nxt.status = ST_SHORT;
    end else if (u_early) begin
      res_nxt.status = ST_VERSION;
    end else if (total_new > u_cnt) begin
      res_nxt.status = ST_LENGTH;
      fields = 1'b1;
    end else if (any_flag && total_new < HDR_CTRL) begin
      res_nxt.status = ST_LENGTH;
      fields = 1'b1;
    end else if (any_flag && (u_werr || u_pend != 8'h00)) begin
      res_nxt.status = ST_LENGTH;
      fields = 1'b1;
      opt    = 1'b1;
    end else begin
      res_nxt.status = ST_OK;
      fields = 1'b1;
      opt    = any_flag;
      res_nxt.header_length = any_flag ? u_xstart : HDR_MIN;
    end
    if (fields) begin
      res_nxt.msg_type       = u_type;
      res_nxt.payload_length = u_len;
      res_nxt.tunnel_id      = u_teid;
      res_nxt.ext_flag       = u_flags[2];
      res_nxt.seq_flag       = u_flags[1];
      res_nxt.npdu_flag      = u_flags[0];
    end
    if (opt) begin
      if ((u_flags & FLAG_S) != 3'h0)  res_nxt.sequence_number = u_seq;
      if ((u_flags & FLAG_PN) != 3'h0) res_nxt.npdu_number     = u_npdu;
      if ((u_flags & FLAG_E) != 3'h0)  res_nxt.first_ext_type  = u_fext;
    end
  end

  // Load the result register on the last byte, drop it once taken
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (s1_adv && s1_last_r) begin
      out_vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid           = out_vld_r;
  assign out_chan.status          = res_r.status;
  assign out_chan.header_length   = res_r.header_length;
  assign out_chan.msg_type        = res_r.msg_type;
  assign out_chan.payload_length  = res_r.payload_length;
  assign out_chan.tunnel_id       = res_r.tunnel_id;
  assign out_chan.sequence_number = res_r.sequence_number;
  assign out_chan.npdu_number     = res_r.npdu_number;
  assign out_chan.first_ext_type  = res_r.first_ext_type;
  assign out_chan.ext_flag        = res_r.ext_flag;
  assign out_chan.seq_flag        = res_r.seq_flag;
  assign out_chan.npdu_flag       = res_r.npdu_flag;

endmodule

/* dv/gtp_v1_header_parser_tb.sv */
// Self-checking testbench for the GTPv1 header parser with a byte-level parse predictor.
module gtp_v1_header_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gtp_pkg::*;

  localparam int RANDOM_BYTES      = 700;
  localparam int MIN_RANDOM_FRAMES = 30;
  localparam int STALL_LIMIT       = 4000;
  localparam int DRAIN_CYCLES      = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       drain;
  } byte_beat_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

  logic clk;
  logic rst_n;

  gtp_in_if  in_if ();
  gtp_out_if out_if ();

  gtp_v1_header_parser u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Stimulus and scoreboard storage
  byte_beat_t  beat_q[$];
  res_t        expect_q[$];
  logic [7:0]  frame_q[$];
  int          ext_pos_q[$];

  int unsigned frames_total;
  int unsigned frames_sent;
  int unsigned frames_in;
  int unsigned results_seen;
  int unsigned stall_cycles;
  int unsigned mismatches;
  int unsigned status_count [4];
  int unsigned max_hdr_len;
  int unsigned max_frame_len;

  // Parse predictor state
  int unsigned hdr_pos;
  int unsigned ext_base;
  int unsigned ext_stop;
  logic [2:0]  hdr_flags;
  logic        hdr_bad;
  logic        walk_bad;
  logic [7:0]  hdr_type;
  logic [15:0] hdr_len;
  logic [31:0] hdr_teid;
  logic [15:0] hdr_seq;
  logic [7:0]  hdr_npdu;
  logic [7:0]  hdr_first_ext;
  logic [7:0]  open_ext;

  always #10ns clk = ~clk;

  // Return the parse predictor to its idle state
  function automatic void clear_parser();
    hdr_pos       = 0;
    ext_base      = 32'(HDR_CTRL);
    ext_stop      = 0;
    hdr_flags     = '0;
    hdr_bad       = 1'b0;
    walk_bad      = 1'b0;
    hdr_type      = '0;
    hdr_len       = '0;
    hdr_teid      = '0;
    hdr_seq       = '0;
    hdr_npdu      = '0;
    hdr_first_ext = '0;
    open_ext      = '0;
  endfunction

  // Advance the parse predictor by one byte; return 1 with the result on the last byte
  function automatic bit parse_byte(input logic [7:0] b, input logic last, output res_t r);
    int unsigned p;
    int unsigned total;
    int unsigned units;
    int unsigned seen;
    logic        any;
    logic        fields;
    logic        opt;
    p      = hdr_pos;
    total  = 32'(HDR_MIN) + 32'(hdr_len);
    r      = '0;
    fields = 1'b0;
    opt    = 1'b0;
    if (p == POS_FLAGS) begin
      hdr_flags = b[2:0];
      hdr_bad   = (b[7:5] != GTP_VERSION) || ((b & PT_BIT) == 8'h00);
    end else if (p == POS_TYPE) begin
      hdr_type = b;
    end else if (p == POS_LEN_H) begin
      hdr_len = {b, 8'h00};
    end else if (p == POS_LEN_L) begin
      hdr_len[7:0] = b;
    end else if (p <= POS_TEID3) begin
      hdr_teid = {hdr_teid[23:0], b};
    end else if (p == POS_SEQ_H) begin
      hdr_seq = {b, 8'h00};
    end else if (p == POS_SEQ_L) begin
      hdr_seq[7:0] = b;
    end else if (p == POS_NPDU) begin
      hdr_npdu = b;
    end else if (p == POS_NEXT) begin
      hdr_first_ext = b;
      if ((hdr_flags & FLAG_E) != 3'b000) open_ext = b;
    end else if (!walk_bad && open_ext != 8'h00) begin
      // Walk the extension chain: length octet at the start, next type at the end
      if (ext_stop != 0) begin
        if (p == ext_stop) begin
          open_ext = b;
          ext_base = p + 1;
          ext_stop = 0;
        end
      end else if (p == ext_base) begin
        units = 32'(b);
        units = units * 4;
        if (ext_base >= total || units == 0 || ext_base + units > total) walk_bad = 1'b1;
        else ext_stop = ext_base + units - 1;
      end
    end
    if (p < CNT_MAX) hdr_pos = p + 1;
    if (!last) return 1'b0;

    // Resolve the status in priority order
    seen = hdr_pos;
    any  = (hdr_flags != 3'b000);
    if (seen < HDR_MIN) begin
      r.status = ST_SHORT;
    end else if (hdr_bad) begin
      r.status = ST_VERSION;
    end else if (total > seen) begin
      r.status = ST_LENGTH;
      fields   = 1'b1;
    end else if (any && total < HDR_CTRL) begin
      r.status = ST_LENGTH;
      fields   = 1'b1;
    end else if (any && (walk_bad || open_ext != 8'h00)) begin
      r.status = ST_LENGTH;
      fields   = 1'b1;
      opt      = 1'b1;
    end else begin
      r.status        = ST_OK;
      fields          = 1'b1;
      opt             = any;
      r.header_length = any ? ext_base[CNT_W-1:0] : HDR_MIN;
    end
    if (fields) begin
      r.msg_type       = hdr_type;
      r.payload_length = hdr_len;
      r.tunnel_id      = hdr_teid;
      r.ext_flag       = |(hdr_flags & FLAG_E);
      r.seq_flag       = |(hdr_flags & FLAG_S);
      r.npdu_flag      = |(hdr_flags & FLAG_PN);
    end
    if (opt) begin
      if ((hdr_flags & FLAG_S) != 3'b000) r.sequence_number = hdr_seq;
      if ((hdr_flags & FLAG_PN) != 3'b000) r.npdu_number = hdr_npdu;
      if ((hdr_flags & FLAG_E) != 3'b000) r.first_ext_type = hdr_first_ext;
    end
    clear_parser();
    return 1'b1;
  endfunction

  task automatic log_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      log_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                             results_seen, name, got, want));
  endtask

  // Compare one result beat against the oldest expectation
  task automatic check_result(input res_t got);
    res_t want;
    if (expect_q.size() == 0) begin
      log_mismatch($sformatf("result %0d arrived with nothing expected (status %0d)",
                             results_seen, got.status));
      return;
    end
    want = expect_q.pop_front();
    check_field("status", 32'(got.status), 32'(want.status));
    check_field("header_length", 32'(got.header_length), 32'(want.header_length));
    check_field("msg_type", 32'(got.msg_type), 32'(want.msg_type));
    check_field("payload_length", 32'(got.payload_length), 32'(want.payload_length));
    check_field("tunnel_id", got.tunnel_id, want.tunnel_id);
    check_field("sequence_number", 32'(got.sequence_number), 32'(want.sequence_number));
    check_field("npdu_number", 32'(got.npdu_number), 32'(want.npdu_number));
    check_field("first_ext_type", 32'(got.first_ext_type), 32'(want.first_ext_type));
    check_field("ext_flag", 32'(got.ext_flag), 32'(want.ext_flag));
    check_field("seq_flag", 32'(got.seq_flag), 32'(want.seq_flag));
    check_field("npdu_flag", 32'(got.npdu_flag), 32'(want.npdu_flag));
  endtask

  // Build a well-formed frame in frame_q; units of zero picks extension sizes at random
  task automatic build_frame(input logic [7:0] first, input int n_ext, input int units,
                             input int pay_len);
    logic [15:0] plen;
    int          n;
    frame_q.delete();
    ext_pos_q.delete();
    frame_q.push_back(first);
    frame_q.push_back(8'($urandom));
    frame_q.push_back(8'h00);
    frame_q.push_back(8'h00);
    repeat (4) frame_q.push_back(8'($urandom));
    if (first[2:0] != 3'b000) begin
      repeat (3) frame_q.push_back(8'($urandom));
      if ((first[2:0] & FLAG_E) == 3'b000) frame_q.push_back(8'($urandom));
      else if (n_ext == 0) frame_q.push_back(8'h00);
      else frame_q.push_back(8'($urandom_range(1, 255)));
      if ((first[2:0] & FLAG_E) != 3'b000) begin
        for (int e = 0; e < n_ext; e++) begin
          if (units > 0) n = units;
          else if ($urandom_range(0, 7) == 0) n = $urandom_range(4, 40);
          else n = $urandom_range(1, 3);
          ext_pos_q.push_back(frame_q.size());
          frame_q.push_back(8'(n));
          repeat (4 * n - 2) frame_q.push_back(8'($urandom));
          frame_q.push_back((e == n_ext - 1) ? 8'h00 : 8'($urandom_range(1, 255)));
        end
      end
    end
    repeat (pay_len) frame_q.push_back(8'($urandom));
    plen       = 16'(frame_q.size() - 8);
    frame_q[2] = plen[15:8];
    frame_q[3] = plen[7:0];
  endtask

  // Append frame_q to the pending beats; drain holds the first byte until all results are in
  task automatic queue_frame(input bit drain);
    byte_beat_t bt;
    for (int i = 0; i < frame_q.size(); i++) begin
      bt.data  = frame_q[i];
      bt.last  = (i == frame_q.size() - 1);
      bt.drain = drain && (i == 0);
      beat_q.push_back(bt);
    end
    if (frame_q.size() > max_frame_len) max_frame_len = frame_q.size();
    frames_total++;
  endtask

  // Sender: bursts of beats with random gaps, paused at drain marks
  int         gap_left;
  int         burst_left;
  byte_beat_t send_beat;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      gap_left   = 0;
      burst_left = $urandom_range(1, 24);
    end else begin
      if (in_if.valid && in_if.ready && in_if.last_byte) frames_sent++;
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (beat_q.size() == 0 ||
                     (beat_q[0].drain && results_seen != frames_sent)) begin
          in_if.valid <= 1'b0;
        end else begin
          send_beat = beat_q.pop_front();
          in_if.data_byte <= send_beat.data;
          in_if.last_byte <= send_beat.last;
          in_if.valid     <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(100, 400);
            else burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Receiver: back-pressure in randomly chosen modes that change over the run
  rx_mode_t    rx_mode;
  int          rx_left;
  int unsigned rx_tick;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_mode = RX_OPEN;
      rx_left = 0;
      rx_tick = 0;
    end else begin
      rx_tick++;
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(32, 400);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_OPEN:   out_if.ready <= 1'b1;
        RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
        default:   out_if.ready <= ((rx_tick % 7) >= 2);
      endcase
    end
  end

  // Monitor: predict on byte beats, check result beats, count idle cycles
  res_t mon_want;
  res_t mon_got;

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        if (parse_byte(in_if.data_byte, in_if.last_byte, mon_want)) begin
          expect_q.push_back(mon_want);
          frames_in <= frames_in + 1;
          status_count[mon_want.status]++;
          if (mon_want.status == ST_OK && mon_want.header_length > max_hdr_len)
            max_hdr_len = 32'(mon_want.header_length);
        end
      end
      if (out_if.valid && out_if.ready) begin
        mon_got.status          = out_if.status;
        mon_got.header_length   = out_if.header_length;
        mon_got.msg_type        = out_if.msg_type;
        mon_got.payload_length  = out_if.payload_length;
        mon_got.tunnel_id       = out_if.tunnel_id;
        mon_got.sequence_number = out_if.sequence_number;
        mon_got.npdu_number     = out_if.npdu_number;
        mon_got.first_ext_type  = out_if.first_ext_type;
        mon_got.ext_flag        = out_if.ext_flag;
        mon_got.seq_flag        = out_if.seq_flag;
        mon_got.npdu_flag       = out_if.npdu_flag;
        check_result(mon_got);
        results_seen <= results_seen + 1;
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Watchdog: %0d cycles without a beat on either channel", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned random_bytes;
    int unsigned random_frames;
    int          pick;
    int          cut;
    logic [2:0]  flags;
    logic [15:0] plen;

    clk              = 1'b0;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.data_byte  = 8'h00;
    in_if.last_byte  = 1'b0;
    out_if.ready     = 1'b0;
    frames_total     = 0;
    frames_sent      = 0;
    frames_in        = 0;
    results_seen     = 0;
    stall_cycles     = 0;
    mismatches       = 0;
    max_hdr_len      = 0;
    max_frame_len    = 0;
    random_bytes     = 0;
    random_frames    = 0;
    foreach (status_count[i]) status_count[i] = 0;
    clear_parser();

    // Single byte: too short
    frame_q.delete();
    frame_q.push_back(8'h30);
    queue_frame(1'b0);
    // Seven bytes: too short
    build_frame(8'h30, 0, 0, 0);
    void'(frame_q.pop_back());
    queue_frame(1'b0);
    // Version 2, then GTP prime, then version 7 with every flag
    build_frame(8'h50, 0, 0, 0);
    queue_frame(1'b0);
    build_frame(8'h20, 0, 0, 0);
    queue_frame(1'b0);
    build_frame(8'hFF, 0, 0, 0);
    queue_frame(1'b0);
    // Minimal header with all-ones type and TEID
    build_frame(8'h30, 0, 0, 0);
    for (int i = 4; i < 8; i++) frame_q[i] = 8'hFF;
    frame_q[1] = 8'hFF;
    queue_frame(1'b0);
    // Minimal header with zero fields and the spare bit set
    build_frame(8'h38, 0, 0, 0);
    for (int i = 1; i < 8; i++) frame_q[i] = 8'h00;
    queue_frame(1'b0);
    // Maximum length field on an eight-byte buffer
    build_frame(8'h30, 0, 0, 0);
    frame_q[2] = 8'hFF;
    frame_q[3] = 8'hFF;
    queue_frame(1'b0);
    // S flag with a length field below the optional part
    build_frame(8'h32, 0, 0, 0);
    frame_q[3] = 8'h00;
    queue_frame(1'b0);
    // S flag, all-ones sequence, next type ignored without E
    build_frame(8'h32, 0, 0, 0);
    frame_q[8]  = 8'hFF;
    frame_q[9]  = 8'hFF;
    frame_q[11] = 8'hFF;
    queue_frame(1'b0);
    // PN flag with payload
    build_frame(8'h31, 0, 0, 4);
    frame_q[10] = 8'hFF;
    queue_frame(1'b0);
    // E flag with no extension, then one, then a chain of three
    build_frame(8'h34, 0, 0, 0);
    queue_frame(1'b0);
    build_frame(8'h34, 1, 1, 0);
    queue_frame(1'b0);
    build_frame(8'h34, 3, 0, 2);
    queue_frame(1'b0);
    // Long extension header
    build_frame(8'h34, 1, 64, 3);
    queue_frame(1'b0);
    // Zero extension length
    build_frame(8'h34, 1, 1, 0);
    frame_q[ext_pos_q[0]] = 8'h00;
    queue_frame(1'b0);
    // Extension running past the length field
    build_frame(8'h34, 2, 1, 0);
    frame_q[ext_pos_q[1]] = 8'hFF;
    queue_frame(1'b0);
    // Chain still open at the end of the header
    build_frame(8'h34, 2, 1, 0);
    frame_q[frame_q.size() - 1] = 8'h85;
    queue_frame(1'b0);
    // Extension announced exactly where the header ends
    build_frame(8'h34, 0, 0, 0);
    frame_q[11] = 8'h85;
    frame_q.push_back(8'h01);
    queue_frame(1'b0);
    // All flags with all-ones fields
    build_frame(8'h37, 1, 2, 0);
    for (int i = 4; i < 11; i++) frame_q[i] = 8'hFF;
    frame_q[1] = 8'hFF;
    queue_frame(1'b0);
    // Buffer longer than the header and payload
    build_frame(8'h33, 0, 0, 6);
    repeat (5) frame_q.push_back(8'($urandom));
    queue_frame(1'b0);

    // Random frames: mostly well formed, some damaged, some noise
    while (random_bytes < RANDOM_BYTES || random_frames < MIN_RANDOM_FRAMES) begin
      pick  = $urandom_range(0, 99);
      flags = ($urandom_range(0, 3) == 0) ? 3'b000 : 3'($urandom_range(1, 7));
      if (pick < 85) begin
        build_frame({3'b001, 1'b1, 1'($urandom), flags}, $urandom_range(0, 3), 0,
                    $urandom_range(0, 12));
        if (pick >= 70) begin
          case ($urandom_range(0, 4))
            0: begin
              cut = $urandom_range(1, frame_q.size() - 1);
              while (frame_q.size() > cut) void'(frame_q.pop_back());
            end
            1: begin
              plen       = {frame_q[2], frame_q[3]} + 16'($urandom_range(0, 8)) - 16'd4;
              frame_q[2] = plen[15:8];
              frame_q[3] = plen[7:0];
            end
            2: begin
              if (ext_pos_q.size() > 0)
                frame_q[ext_pos_q[$urandom_range(0, ext_pos_q.size() - 1)]] = 8'h00;
              else
                frame_q[0] = frame_q[0] ^ (8'h01 << $urandom_range(0, 7));
            end
            3: repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom));
            default: begin
              cut          = $urandom_range(0, frame_q.size() - 1);
              frame_q[cut] = frame_q[cut] ^ (8'h01 << $urandom_range(0, 7));
            end
          endcase
        end
      end else begin
        frame_q.delete();
        repeat ($urandom_range(1, 30)) frame_q.push_back(8'($urandom));
        if ($urandom_range(0, 1) == 0) frame_q[0] = {3'b001, 1'b1, 4'($urandom)};
      end
      // The first random frame waits for the directed results to drain
      queue_frame(random_frames == 0 || $urandom_range(0, 19) == 0);
      random_bytes += frame_q.size();
      random_frames++;
    end

    // Release reset and wait for every frame to be parsed and checked
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (frames_in != frames_total) @(posedge clk);
    while (expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Parsed %0d buffers: %0d ok, %0d short, %0d bad version, %0d length errors",
             frames_total, status_count[ST_OK], status_count[ST_SHORT],
             status_count[ST_VERSION], status_count[ST_LENGTH]);
    $display("Longest good header %0d bytes, longest buffer %0d bytes, %0d mismatches",
             max_hdr_len, max_frame_len, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
